[src/urc_pkg.sv]
// Shared types, widths and constants for the ultrasonic ranger controller.
`timescale 1ns / 1ps

package urc_pkg;

	// Counter and field widths
	localparam int COUNT_BITS    = 24;
	localparam int PHASE_BITS    = 24;
	localparam int DIST_BITS     = 22;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 24;

	// Trigger pulse length in ticks
	localparam logic [PHASE_BITS-1:0] TRIG_PULSE_TICKS = PHASE_BITS'(10);

	// Divide by six: floor(w * ceil(2^26 / 6) / 2^26) is exact for all w below 2^24
	localparam logic [COUNT_BITS-1:0] DIV6_MULT  = 24'hAAAAAB;
	localparam int                    DIV6_SHIFT = 26;

	// Request codes
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT = 2'd2;

	// Configuration reset values
	localparam logic [CFG_DATA_BITS-1:0] PERIOD_RESET  = CFG_DATA_BITS'(100000);
	localparam logic [CFG_DATA_BITS-1:0] TIMEOUT_RESET = CFG_DATA_BITS'(30000);

	// One result word
	typedef struct packed {
		logic                 trig_level;
		logic [DIST_BITS-1:0] distance;
		logic                 updated;
	} urc_result_t;

endpackage

[src/urc_if.sv]
// Handshake channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface urc_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic echo_level;

	modport source (output valid, output req_type, output echo_level, input ready);
	modport sink (input valid, input req_type, input echo_level, output ready);
endinterface

interface urc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         trig_level;
	logic [urc_pkg::DIST_BITS-1:0] distance;
	logic                         updated;

	modport source (output valid, output trig_level, output distance, output updated,
		input ready);
	modport sink (input valid, input trig_level, input distance, input updated,
		output ready);
endinterface

interface urc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [urc_pkg::CFG_IDX_BITS-1:0]  index;
	logic [urc_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/urc_div6.sv]
// Echo width to distance: divide by six through a reciprocal multiply.
`timescale 1ns / 1ps

module urc_div6 (
	input  logic [urc_pkg::COUNT_BITS-1:0] width,
	output logic [urc_pkg::DIST_BITS-1:0]  quotient
);
	import urc_pkg::*;

	logic [2*COUNT_BITS-1:0] prod;

	assign prod     = (2*COUNT_BITS)'(width) * (2*COUNT_BITS)'(DIV6_MULT);
	assign quotient = prod[DIV6_SHIFT +: DIST_BITS];

endmodule

[src/urc_core.sv]
// Measurement sequencer: trigger pulse, echo timing, hold and status flag.
`timescale 1ns / 1ps

module urc_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic                             req_type,
	input  logic                             echo_level,
	input  logic                             enable,
	input  logic [urc_pkg::CFG_DATA_BITS-1:0] period,
	input  logic [urc_pkg::CFG_DATA_BITS-1:0] timeout,
	output urc_pkg::urc_result_t             result
);
	import urc_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_HOLD
	} phase_t;

	phase_t                phase_q, phase_n;
	logic [PHASE_BITS-1:0] count_q, count_n, count_inc;
	logic [COUNT_BITS-1:0] width_q, width_n;
	logic                  prev_q, prev_n;
	logic [DIST_BITS-1:0]  dist_q, dist_n, dist_calc;
	logic                  flag_q, flag_n;
	logic                  flag_out;

	urc_div6 u_div6 (
		.width    (width_q),
		.quotient (dist_calc)
	);

	assign count_inc = (count_q == '1) ? count_q : count_q + PHASE_BITS'(1);

	always_comb begin
		phase_n  = phase_q;
		count_n  = count_q;
		width_n  = width_q;
		prev_n   = prev_q;
		dist_n   = dist_q;
		flag_n   = flag_q;
		flag_out = flag_q;
		if (req_type == REQ_READ) begin
			// status read: report the flag, then drop it
			flag_n = 1'b0;
		end else begin
			if (!enable) begin
				phase_n = PH_IDLE;
				count_n = '0;
			end else begin
				unique case (phase_q)
					PH_TRIG: begin
						count_n = count_inc;
						if (count_inc >= TRIG_PULSE_TICKS) begin
							phase_n = PH_WAIT;
							count_n = '0;
							width_n = '0;
						end
					end
					PH_WAIT: begin
						count_n = count_inc;
						if (prev_q && !echo_level) begin
							dist_n  = dist_calc;
							flag_n  = 1'b1;
							phase_n = PH_HOLD;
							count_n = '0;
						end else begin
							if (echo_level) begin
								if (!prev_q) begin
									width_n = COUNT_BITS'(1);
								end else if (width_q != '1) begin
									width_n = width_q + COUNT_BITS'(1);
								end
							end
							if (count_inc >= timeout) begin
								phase_n = PH_TRIG;
								count_n = '0;
								flag_n  = 1'b0;
							end
						end
					end
					PH_HOLD: begin
						count_n = count_inc;
						if (count_inc >= period) begin
							phase_n = PH_TRIG;
							count_n = '0;
							flag_n  = 1'b0;
						end
					end
					default: begin
						phase_n = PH_TRIG;
						count_n = '0;
						flag_n  = 1'b0;
					end
				endcase
			end
			prev_n   = echo_level;
			flag_out = flag_n;
		end
	end

	assign result.trig_level = (phase_n == PH_TRIG);
	assign result.distance   = dist_n;
	assign result.updated    = flag_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			width_q <= '0;
			prev_q  <= 1'b0;
			dist_q  <= '0;
			flag_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			count_q <= count_n;
			width_q <= width_n;
			prev_q  <= prev_n;
			dist_q  <= dist_n;
			flag_q  <= flag_n;
		end
	end

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && req_type == REQ_READ |=> !flag_q)
		else $error("flag still set after status read");

	a_disable_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && req_type == REQ_TICK && !enable |=> phase_q == PH_IDLE && count_q == '0)
		else $error("disabled tick did not return to idle");

	a_pulse_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TRIG |-> count_q < TRIG_PULSE_TICKS)
		else $error("trigger pulse overran its length");

	a_flag_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && req_type == REQ_TICK && phase_q == PH_WAIT && prev_q && !echo_level
		&& enable |=> flag_q && phase_q == PH_HOLD)
		else $error("echo fall did not complete a measurement");

endmodule

[src/ultrasonic_ranger_controller.sv]
// Top level of the ultrasonic ranger controller: config registers, sequencer, result register.
// Output: a result word is registered and appears on rsp in the cycle after its request word is accepted.
// Throughput: one request word per cycle; req stalls only while the result register
// holds a word that rsp has not taken.
// Reset: configuration returns to defaults, the sequencer goes idle, flag and distance clear.
`timescale 1ns / 1ps

module ultrasonic_ranger_controller (
	input  logic           clk,
	input  logic           arst_n,
	urc_req_if.sink        req,
	urc_rsp_if.source      rsp,
	urc_cfg_if.sink        cfg
);
	import urc_pkg::*;

	logic                     enable_q;
	logic [CFG_DATA_BITS-1:0] period_q;
	logic [CFG_DATA_BITS-1:0] timeout_q;

	logic        req_accept;
	urc_result_t result;
	urc_result_t rsp_word_q;
	logic        rsp_valid_q;

	// Configuration writes are always taken; writes outside the register list drop.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			period_q  <= PERIOD_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ENABLE:  enable_q  <= cfg.data[0];
				CFG_PERIOD:  period_q  <= cfg.data;
				CFG_TIMEOUT: timeout_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Take a new word whenever the result register is empty or drains this cycle.
	assign req.ready  = !rsp_valid_q || rsp.ready;
	assign req_accept = req.valid && req.ready;

	// The sequencer advances its state only on accepted words.
	urc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (req_accept),
		.req_type   (req.req_type),
		.echo_level (req.echo_level),
		.enable     (enable_q),
		.period     (period_q),
		.timeout    (timeout_q),
		.result     (result)
	);

	// Result register: hold the word until rsp takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			rsp_word_q <= result;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.trig_level = rsp_word_q.trig_level;
	assign rsp.distance   = rsp_word_q.distance;
	assign rsp.updated    = rsp_word_q.updated;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !req_accept)
		else $error("request accepted over an untaken result");

	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> rsp_valid_q)
		else $error("accepted request produced no result word");

	a_cfg_held: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.valid |=> $stable(enable_q) && $stable(period_q) && $stable(timeout_q))
		else $error("configuration changed without a write");

endmodule

[dv/ultrasonic_ranger_controller_tb.sv]
// Testbench for the ultrasonic ranger controller: emulated sensor against a shadow ranger.
`timescale 1ns / 1ps

module ultrasonic_ranger_controller_tb;
	import urc_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int STALL_LIMIT    = 2000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int PHASE_WORDS    = 240;
	localparam int RANDOM_PHASES  = 8;
	localparam int PRINT_LIMIT    = 100;
	localparam int DIST_DIVISOR   = 6;
	localparam int SETTLE_CYCLES  = 4;

	// Index past the last register; writes to it must leave every register alone
	localparam logic [CFG_IDX_BITS-1:0]  CFG_UNUSED = 2'd3;
	localparam logic [COUNT_BITS-1:0]    WIDTH_MAX  = '1;
	localparam logic [PHASE_BITS-1:0]    COUNT_MAX  = '1;
	localparam logic [CFG_DATA_BITS-1:0] CFG_MAX    = '1;

	typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_HOLD} ranger_phase_t;

	logic clk;
	logic arst_n;

	urc_req_if req_ch ();
	urc_rsp_if rsp_ch ();
	urc_cfg_if cfg_ch ();

	ultrasonic_ranger_controller uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the configuration registers
	logic                     sh_enable;
	logic [CFG_DATA_BITS-1:0] sh_period;
	logic [CFG_DATA_BITS-1:0] sh_timeout;

	// Shadow copy of the ranging sequencer
	ranger_phase_t        sh_phase;
	logic [PHASE_BITS-1:0] sh_count;
	logic [COUNT_BITS-1:0] sh_width;
	logic                  sh_echo_prev;
	logic [DIST_BITS-1:0]  sh_distance;
	logic                  sh_flag;

	// Result words still owed by the block, oldest first
	urc_result_t pending_readings[$];

	int error_count = 0;
	int idle_cycles = 0;
	int holdoff_left = 0;
	int stall_left = 0;

	bit sender_no_gaps = 1'b0;
	bit sink_no_stalls = 1'b0;
	bit holdoff_req = 1'b0;

	// Emulated sensor: pending echo delay and length for the current pulse
	int echo_delay = 0;
	int echo_len = 0;
	bit echo_early = 1'b0;
	bit echo_noise = 1'b0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Period or timeout: mostly small, with zero, one, the maximum and raw random words
	function automatic logic [CFG_DATA_BITS-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 14)
			return CFG_DATA_BITS'(1);
		if (r < 18)
			return CFG_MAX;
		if (r < 26)
			return CFG_DATA_BITS'($urandom());
		return CFG_DATA_BITS'($urandom_range(2, 150));
	endfunction

	function automatic logic [PHASE_BITS-1:0] sat_inc(input logic [PHASE_BITS-1:0] v);
		return (v == COUNT_MAX) ? v : v + PHASE_BITS'(1);
	endfunction

	// Fire a new trigger pulse; a pulse always clears the new-distance flag
	function automatic void fire_trigger();
		sh_phase = PH_TRIG;
		sh_count = '0;
		sh_flag = 1'b0;
	endfunction

	// Advance the shadow ranger by one request word and return the word it should answer
	function automatic urc_result_t ranger_step(input logic rtype, input logic echo);
		urc_result_t res;
		logic flag_seen;
		if (rtype == REQ_READ) begin
			// A read reports the flag and clears it; echo history is left alone
			flag_seen = sh_flag;
			sh_flag = 1'b0;
		end else begin
			if (!sh_enable) begin
				sh_phase = PH_IDLE;
				sh_count = '0;
			end else begin
				case (sh_phase)
					PH_TRIG: begin
						sh_count = sat_inc(sh_count);
						if (sh_count >= TRIG_PULSE_TICKS) begin
							sh_phase = PH_WAIT;
							sh_count = '0;
							sh_width = '0;
						end
					end
					PH_WAIT: begin
						sh_count = sat_inc(sh_count);
						if (sh_echo_prev && !echo) begin
							// Falling edge closes the measurement
							sh_distance = DIST_BITS'(sh_width / DIST_DIVISOR);
							sh_flag = 1'b1;
							sh_phase = PH_HOLD;
							sh_count = '0;
						end else begin
							if (echo) begin
								if (!sh_echo_prev)
									sh_width = COUNT_BITS'(1);
								else if (sh_width != WIDTH_MAX)
									sh_width = sh_width + COUNT_BITS'(1);
							end
							if (sh_count >= sh_timeout)
								fire_trigger();
						end
					end
					PH_HOLD: begin
						sh_count = sat_inc(sh_count);
						if (sh_count >= sh_period)
							fire_trigger();
					end
					default: begin
						fire_trigger();
					end
				endcase
			end
			sh_echo_prev = echo;
			flag_seen = sh_flag;
		end
		res.trig_level = (sh_phase == PH_TRIG);
		res.distance = sh_distance;
		res.updated = flag_seen;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (error_count < PRINT_LIMIT)
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Offer one request word after a random gap, hold it until accepted, then predict it.
	// Enter and leave at a falling edge so valid stays up between back-to-back words.
	task automatic send_word(input logic rtype, input logic echo);
		int gap;
		gap = sender_no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = rtype;
		req_ch.echo_level = echo;
		do @(posedge clk); while (!req_ch.ready);
		pending_readings.push_back(ranger_step(rtype, echo));
		@(negedge clk);
	endtask

	// Write one register; the shadow copy follows on acceptance
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_ENABLE:  sh_enable = value[0];
			CFG_PERIOD:  sh_period = value;
			CFG_TIMEOUT: sh_timeout = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Drop valid and wait until every owed word has come back
	task automatic settle();
		req_ch.valid = 1'b0;
		wait (pending_readings.size() == 0);
		@(negedge clk);
	endtask

	// Drive ticks from an emulated sensor: each pulse gets an echo after a short delay,
	// sometimes none (timeout), sometimes one already high during the pulse.
	// Reads are sprinkled in; noise mode drives random echo levels instead.
	task automatic run_ranging(input int words);
		logic echo;
		int r;
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				send_word(REQ_READ, 1'($urandom_range(0, 1)));
				continue;
			end
			if (echo_noise) begin
				echo = 1'($urandom_range(0, 1));
			end else if (sh_phase == PH_TRIG) begin
				// Arm the echo on the first tick of each pulse
				if (sh_count == '0) begin
					echo_early = ($urandom_range(0, 9) == 0);
					echo_delay = echo_early ? 0 : $urandom_range(0, 12);
					r = $urandom_range(0, 99);
					if (r < 5)
						echo_len = 0;
					else if (r < 75)
						echo_len = $urandom_range(1, 40);
					else
						echo_len = $urandom_range(41, 400);
				end
				echo = echo_early;
			end else if (sh_phase == PH_WAIT && echo_delay > 0) begin
				echo_delay--;
				echo = 1'b0;
			end else if (echo_len > 0) begin
				echo_len--;
				echo = 1'b1;
			end else begin
				echo = 1'b0;
			end
			send_word(REQ_TICK, echo);
		end
	endtask

	// Disabled after reset: ticks keep the trigger low, reads return a clear flag
	task automatic test_idle_and_read();
		send_word(REQ_TICK, 1'b1);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_READ, 1'b0);
		send_word(REQ_READ, 1'b1);
	endtask

	// Echo high across the whole pulse, six more high ticks, then a fall: distance one.
	// Zero update period retriggers on the first hold tick.
	task automatic test_echo_over_pulse();
		settle();
		write_reg(CFG_ENABLE, CFG_DATA_BITS'(1));
		write_reg(CFG_PERIOD, '0);
		write_reg(CFG_TIMEOUT, CFG_DATA_BITS'(40));
		repeat (17) send_word(REQ_TICK, 1'b1);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_READ, 1'b0);
		send_word(REQ_TICK, 1'b0);
	endtask

	// Unused index is ignored; period and timeout at their maximum
	task automatic test_register_extremes();
		settle();
		write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom()));
		write_reg(CFG_PERIOD, CFG_MAX);
		write_reg(CFG_TIMEOUT, CFG_MAX);
		send_word(REQ_TICK, 1'b0);
		send_word(REQ_TICK, 1'b1);
		send_word(REQ_READ, 1'b0);
	endtask

	// Hold rsp off for a long stretch while words keep coming, so req must stall
	task automatic test_backpressure();
		settle();
		write_reg(CFG_ENABLE, CFG_DATA_BITS'(1));
		write_reg(CFG_PERIOD, CFG_DATA_BITS'(5));
		write_reg(CFG_TIMEOUT, CFG_DATA_BITS'(60));
		sender_no_gaps = 1'b1;
		echo_noise = 1'b0;
		@(posedge clk);
		holdoff_req = 1'b1;
		@(negedge clk);
		run_ranging(60);
		sender_no_gaps = 1'b0;
	endtask

	// Several settings in turn, each with its own idling and echo style
	task automatic test_random_ranging();
		logic [CFG_DATA_BITS-1:0] en_word;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			write_reg(CFG_PERIOD, pick_count());
			// One phase always runs with a zero timeout
			write_reg(CFG_TIMEOUT, (p == 1) ? '0 : pick_count());
			en_word = CFG_DATA_BITS'($urandom());
			en_word[0] = ($urandom_range(0, 5) != 0);
			write_reg(CFG_ENABLE, en_word);
			sender_no_gaps = ($urandom_range(0, 3) == 0);
			sink_no_stalls = ($urandom_range(0, 3) == 0);
			echo_noise = ($urandom_range(0, 5) == 0);
			run_ranging(PHASE_WORDS);
		end
	endtask

	// Receiver: random stalls, a stall-free mode, and the long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_req = 1'b0;
			end
			if (holdoff_left > 0) begin
				rsp_ch.ready = 1'b0;
				holdoff_left--;
			end else if (sink_no_stalls) begin
				rsp_ch.ready = 1'b1;
			end else if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Compare each accepted result word with the oldest owed one, field by field
	always @(posedge clk) begin
		urc_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("result word with none owed", 32'(rsp_ch.distance), 32'd0);
			end else begin
				want = pending_readings.pop_front();
				if (rsp_ch.trig_level !== want.trig_level)
					report_mismatch("trig_level", 32'(rsp_ch.trig_level),
						32'(want.trig_level));
				if (rsp_ch.distance !== want.distance)
					report_mismatch("distance", 32'(rsp_ch.distance), 32'(want.distance));
				if (rsp_ch.updated !== want.updated)
					report_mismatch("updated", 32'(rsp_ch.updated), 32'(want.updated));
			end
		end
	end

	// Watchdog: end the run when no channel moves a word for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		// Hold every input at a known value and the block in reset
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TICK;
		req_ch.echo_level = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_ENABLE;
		cfg_ch.data = '0;

		// Shadow state after reset
		sh_enable = 1'b0;
		sh_period = PERIOD_RESET;
		sh_timeout = TIMEOUT_RESET;
		sh_phase = PH_IDLE;
		sh_count = '0;
		sh_width = '0;
		sh_echo_prev = 1'b0;
		sh_distance = '0;
		sh_flag = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_and_read();
		test_echo_over_pulse();
		test_register_extremes();
		test_backpressure();
		test_random_ranging();

		// Drain, then give the result register time to show anything stray
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_readings.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
